// ===== src/tor_pkg.sv =====
`default_nettype none

package tor_pkg;

  localparam logic [7:0] TN_IAC  = 8'd255;
  localparam logic [7:0] TN_DONT = 8'd254;
  localparam logic [7:0] TN_DO   = 8'd253;
  localparam logic [7:0] TN_WONT = 8'd252;
  localparam logic [7:0] TN_WILL = 8'd251;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  typedef struct packed {
    logic       reply;
    logic       wont;
    logic [7:0] value;
  } job_t;

endpackage

`default_nettype wire

// ===== src/tor_ifs.sv =====
`default_nettype none

interface tor_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tor_result_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink (input valid, input kind, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== src/tor_front.sv =====
`default_nettype none

module tor_front (
  input  wire           clk,
  input  wire           rst,
  tor_byte_if.sink      rx,
  output logic          push,
  output tor_pkg::job_t push_job,
  input  wire           full
);
  import tor_pkg::*;

  typedef enum logic [2:0] {
    PH_DATA = 3'b001,
    PH_CMD  = 3'b010,
    PH_OPT  = 3'b100
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic       wont;
  logic       wont_next;
  logic       take;
  logic [7:0] b;

  assign rx.ready = !full;
  assign take     = rx.valid && rx.ready;
  assign b        = rx.rx_byte;

  always_comb begin
    phase_next     = phase;
    wont_next      = wont;
    push           = 1'b0;
    push_job.reply = KIND_DATA;
    push_job.wont  = wont;
    push_job.value = b;
    if (take) begin
      unique case (phase)
        PH_CMD: begin
          if (b == TN_DO || b == TN_DONT) begin
            wont_next  = 1'b1;
            phase_next = PH_OPT;
          end else if (b == TN_WILL || b == TN_WONT) begin
            wont_next  = 1'b0;
            phase_next = PH_OPT;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_OPT: begin
          push           = 1'b1;
          push_job.reply = KIND_REPLY;
          phase_next     = PH_DATA;
        end
        default: begin
          phase_next = PH_DATA;
          if (b == TN_IAC) begin
            phase_next = PH_CMD;
          end else if (b != 8'd0) begin
            push = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DATA;
      wont  <= 1'b0;
    end else begin
      phase <= phase_next;
      wont  <= wont_next;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

endmodule

`default_nettype wire

// ===== src/tor_queue.sv =====
`default_nettype none

module tor_queue #(
  parameter int DEPTH = 4
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  wire tor_pkg::job_t push_job,
  output logic               full,
  input  wire                pop,
  output tor_pkg::job_t      head_job,
  output logic               empty
);
  import tor_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;
  assign head_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count overflow");

endmodule

`default_nettype wire

// ===== src/tor_back.sv =====
`default_nettype none

module tor_back (
  input  wire                clk,
  input  wire                rst,
  input  wire tor_pkg::job_t head_job,
  input  wire                empty,
  output logic               pop,
  tor_result_if.source       tx
);
  import tor_pkg::*;

  typedef enum logic [2:0] {
    ST_HEAD = 3'b001,
    ST_VERB = 3'b010,
    ST_OPT  = 3'b100
  } step_t;

  step_t      step;
  step_t      step_next;
  logic       load;
  logic       out_valid;
  logic       out_kind;
  logic [7:0] out_byte;
  logic       out_last;
  logic       beat_kind;
  logic [7:0] beat_byte;
  logic       beat_last;

  assign tx.valid    = out_valid;
  assign tx.kind     = out_kind;
  assign tx.out_byte = out_byte;
  assign tx.last     = out_last;
  assign load        = !out_valid || tx.ready;

  always_comb begin
    step_next = step;
    pop       = 1'b0;
    beat_kind = head_job.reply;
    beat_byte = head_job.value;
    beat_last = 1'b1;
    if (head_job.reply == KIND_DATA) begin
      pop = load && !empty;
    end else begin
      unique case (step)
        ST_VERB: begin
          beat_byte = head_job.wont ? TN_WONT : TN_DONT;
          beat_last = 1'b0;
          step_next = ST_OPT;
        end
        ST_OPT: begin
          pop       = load && !empty;
          step_next = ST_HEAD;
        end
        default: begin
          beat_byte = TN_IAC;
          beat_last = 1'b0;
          step_next = ST_VERB;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= ST_HEAD;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        step <= step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      out_kind <= beat_kind;
      out_byte <= beat_byte;
      out_last <= beat_last;
    end
  end

  a_data_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_DATA |-> out_last)
    else $error("data beat without last");

  a_reply_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && tx.ready && out_kind == KIND_REPLY && !out_last |=> out_valid)
    else $error("gap inside reply");

  a_step_entry: assert property (@(posedge clk) disable iff (rst)
    step != ST_HEAD |-> !empty)
    else $error("reply in progress with empty queue");

endmodule

`default_nettype wire

// ===== src/telnet_option_refuse_filter_unit.sv =====
`default_nettype none

// channel | dir | handshake    | payload
// rx      | in  | valid/ready  | rx_byte[7:0]
// tx      | out | valid/ready  | kind, out_byte[7:0], last
//
// rx takes one byte per cycle while the job queue (DEPTH entries) has room.
// tx gives one beat per cycle while tx ready is high, from an output register: one beat per data byte,
// three beats per refusal, so a refusal holds the queue head until its third beat is loaded.
// An rx beat reaches tx through its job queue entry and then the tx output register.
// rst is synchronous, active high; it clears phase, queue pointers and tx valid.
// A stall on tx fills the queue; rx ready drops only when the queue is full.
module telnet_option_refuse_filter_unit #(
  parameter int DEPTH = 4
) (
  input  wire          clk,
  input  wire          rst,
  tor_byte_if.sink     rx,
  tor_result_if.source tx
);
  import tor_pkg::*;

  logic push;
  job_t push_job;
  logic full;
  logic pop;
  job_t head_job;
  logic empty;

  tor_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  tor_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (empty)
  );

  tor_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_job (head_job),
    .empty    (empty),
    .pop      (pop),
    .tx       (tx)
  );

endmodule

`default_nettype wire

// ===== tb/tb_telnet_option_refuse_filter_unit.sv =====
`timescale 1ns / 100ps

module tb_telnet_option_refuse_filter_unit;
  import tor_pkg::*;

  typedef enum logic [1:0] {IN_TEXT, AFTER_IAC, AWAIT_OPTION} rx_phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic       last;
  } tx_beat_t;

  class refusal_scoreboard_t;
    rx_phase_t  phase;
    logic       refuse_with_wont;
    tx_beat_t   expected_beats[$];
    int         errors;
    int         checked;
    int         data_beats;
    int         refusals;
    int         dropped;

    function new();
      phase = IN_TEXT;
      refuse_with_wont = 1'b0;
    endfunction

    function int outstanding();
      return expected_beats.size();
    endfunction

    function void queue_beat(logic kind, logic [7:0] value, logic last);
      tx_beat_t b;
      b.kind = kind;
      b.out_byte = value;
      b.last = last;
      expected_beats = {expected_beats, b};
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("mismatch at %0t: %s", $time, msg);
    endtask

    function void take_rx_byte(logic [7:0] value);
      case (phase)
        AFTER_IAC: begin
          if (value == TN_DO || value == TN_DONT) begin
            refuse_with_wont = 1'b1;
            phase = AWAIT_OPTION;
          end else if (value == TN_WILL || value == TN_WONT) begin
            refuse_with_wont = 1'b0;
            phase = AWAIT_OPTION;
          end else begin
            dropped++;
            phase = IN_TEXT;
          end
        end
        AWAIT_OPTION: begin
          queue_beat(KIND_REPLY, TN_IAC, 1'b0);
          queue_beat(KIND_REPLY, refuse_with_wont ? TN_WONT : TN_DONT, 1'b0);
          queue_beat(KIND_REPLY, value, 1'b1);
          refusals++;
          phase = IN_TEXT;
        end
        default: begin
          phase = IN_TEXT;
          if (value == TN_IAC) begin
            phase = AFTER_IAC;
          end else if (value == 8'd0) begin
            dropped++;
          end else begin
            queue_beat(KIND_DATA, value, 1'b1);
            data_beats++;
          end
        end
      endcase
    endfunction

    task check_tx_beat(logic kind, logic [7:0] value, logic last);
      tx_beat_t want;
      string    diffs;
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("beat kind=%0d byte=%02h last=%0d with nothing expected",
                                  kind, value, last));
        return;
      end
      want = expected_beats.pop_front();
      diffs = "";
      if (kind !== want.kind)
        diffs = {diffs, $sformatf(" kind %0d/%0d", kind, want.kind)};
      if (value !== want.out_byte)
        diffs = {diffs, $sformatf(" out_byte %02h/%02h", value, want.out_byte)};
      if (last !== want.last)
        diffs = {diffs, $sformatf(" last %0d/%0d", last, want.last)};
      if (diffs != "")
        report_mismatch($sformatf("beat %0d (got/expected):%s", checked, diffs));
      checked++;
    endtask

    task flush_leftovers();
      tx_beat_t want;
      while (expected_beats.size() != 0) begin
        want = expected_beats.pop_front();
        report_mismatch($sformatf("beat kind=%0d byte=%02h last=%0d never arrived",
                                  want.kind, want.out_byte, want.last));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic hold_off = 1'b0;
  logic calm = 1'b0;
  int   rx_beats = 0;
  int   rx_stalls = 0;

  refusal_scoreboard_t sb = new();

  tor_byte_if   rx_link ();
  tor_result_if tx_link ();

  telnet_option_refuse_filter_unit dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_link),
    .tx  (tx_link)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rx_link.valid && rx_link.ready) begin
        sb.take_rx_byte(rx_link.rx_byte);
        rx_beats++;
      end
      if (rx_link.valid && !rx_link.ready) rx_stalls++;
      if (tx_link.valid && tx_link.ready)
        sb.check_tx_beat(tx_link.kind, tx_link.out_byte, tx_link.last);
    end
  end

  // hold tx ready low in random bursts; none once the run turns calm
  initial begin : tx_sink
    int stall_left;
    stall_left = 0;
    tx_link.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        tx_link.ready <= 1'b0;
      end else if (stall_left > 0) begin
        tx_link.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        tx_link.ready <= 1'b0;
      end else begin
        tx_link.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the job queue fills and rx backs up
  initial begin
    wait (rx_beats >= 80);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (60) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #600000;
    $display("timeout with %0d beats still expected", sb.outstanding());
    $display("FAIL telnet_option_refuse_filter_unit");
    $finish;
  end

  task automatic send_byte(input logic [7:0] value);
    int gap;
    gap = 0;
    if (!calm && !hold_off && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      rx_link.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_link.valid <= 1'b1;
    rx_link.rx_byte <= value;
    do @(posedge clk); while (!rx_link.ready);
  endtask

  task automatic send_negotiation(input logic [7:0] verb, input logic [7:0] option);
    send_byte(TN_IAC);
    send_byte(verb);
    send_byte(option);
  endtask

  initial begin : stimulus
    int         counted;
    int         pick;
    int         k;
    logic [7:0] value;
    counted = 0;
    rst <= 1'b1;
    rx_link.valid <= 1'b0;
    rx_link.rx_byte <= 8'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h7f);
    send_byte(8'h80);
    send_byte(8'hfe);
    send_negotiation(TN_DO, 8'h00);
    send_negotiation(TN_DONT, 8'hff);
    send_negotiation(TN_WILL, 8'h18);
    send_negotiation(TN_WONT, 8'haa);
    send_byte(TN_IAC);
    send_byte(TN_IAC);
    send_byte(TN_IAC);
    send_byte(8'h41);
    send_byte(TN_WILL);

    while (counted < 310) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_byte(8'($urandom_range(1, 254)));
        counted++;
      end else if (pick < 50) begin
        value = 8'($urandom_range(0, 255));
        send_byte(value);
        counted++;
      end else if (pick < 80) begin
        send_negotiation(8'($urandom_range(TN_WILL, TN_DONT)), 8'($urandom_range(0, 255)));
        counted += 3;
      end else if (pick < 90) begin
        send_byte(TN_IAC);
        do value = 8'($urandom_range(0, 255)); while (value >= TN_WILL && value <= TN_DONT);
        send_byte(value);
        counted += 2;
      end else begin
        send_byte(TN_IAC);
        send_byte(TN_IAC);
        counted += 2;
      end
      if (counted >= 250 && !calm) calm <= 1'b1;
    end
    rx_link.valid <= 1'b0;

    for (k = 0; k < 4000 && sb.outstanding() != 0; k++) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.flush_leftovers();

    $display("covered %0d rx bytes: %0d data bytes, %0d refusals, %0d bytes dropped",
             rx_beats, sb.data_beats, sb.refusals, sb.dropped);
    $display("checked %0d tx beats; rx was back-pressured for %0d cycles",
             sb.checked, rx_stalls);
    if (sb.errors == 0) begin
      $display("PASS telnet_option_refuse_filter_unit");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAIL telnet_option_refuse_filter_unit");
    end
    $finish;
  end

endmodule
